@@ hdl/s2c_pkg.sv @@
// s2c_pkg: shared constants, types and functions for spherical_to_cartesian
// holds the degree cordic angle table and fixed point formats; no dependencies
package s2c_pkg;

  localparam int CordicStages = 16;
  localparam int TableLen     = 24;
  localparam int NStages      = (CordicStages < TableLen) ? CordicStages : TableLen;
  localparam int CW           = 28;   // cordic x/y width, q24 plus guard
  localparam int ZW           = 30;   // angle accumulator width, q20 degrees
  localparam int SIdxW        = $clog2(TableLen);

  localparam logic signed [CW-1:0] GainQ24 = 28'sd10188014;
  localparam logic signed [17:0] Deg90Q8  = 18'sd23040;
  localparam logic signed [17:0] Deg180Q8 = 18'sd46080;
  localparam logic signed [18:0] Deg360Q8 = 19'sd92160;
  localparam logic signed [16:0] OutMax   = 17'sd65535;

  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [ZW-1:0] zw_t;

  function automatic zw_t atan_deg(input logic [SIdxW-1:0] idx);
    zw_t v;
    unique case (idx)
      5'd0:  v = 30'sd47185920;
      5'd1:  v = 30'sd27855475;
      5'd2:  v = 30'sd14718068;
      5'd3:  v = 30'sd7471121;
      5'd4:  v = 30'sd3750058;
      5'd5:  v = 30'sd1876857;
      5'd6:  v = 30'sd938658;
      5'd7:  v = 30'sd469357;
      5'd8:  v = 30'sd234682;
      5'd9:  v = 30'sd117342;
      5'd10: v = 30'sd58671;
      5'd11: v = 30'sd29335;
      5'd12: v = 30'sd14668;
      5'd13: v = 30'sd7334;
      5'd14: v = 30'sd3667;
      5'd15: v = 30'sd1833;
      5'd16: v = 30'sd917;
      5'd17: v = 30'sd458;
      5'd18: v = 30'sd229;
      5'd19: v = 30'sd115;
      5'd20: v = 30'sd57;
      5'd21: v = 30'sd29;
      5'd22: v = 30'sd14;
      5'd23: v = 30'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [17:0] ang;  // reduced q8 degrees within +-90
    logic               flip;
  } red_t;

  // wrap into [-180,180), then fold into +-90
  function automatic red_t reduce(input logic signed [17:0] a_in);
    logic signed [18:0] a;
    red_t r;
    a = 19'(a_in);
    if (a >= 19'(Deg180Q8)) a = a - Deg360Q8;
    if (a < -19'(Deg180Q8)) a = a + Deg360Q8;
    r.flip = 1'b0;
    if (a > 19'(Deg90Q8)) begin
      a = a - 19'(Deg180Q8);
      r.flip = 1'b1;
    end else if (a < -19'(Deg90Q8)) begin
      a = a + 19'(Deg180Q8);
      r.flip = 1'b1;
    end
    r.ang = a[17:0];
    return r;
  endfunction

endpackage

@@ hdl/s2c_cordic.sv @@
// s2c_cordic: pipelined rotation cordic giving cosine and sine in q24
// one register stage per iteration plus input reduction; uses s2c_pkg
module s2c_cordic import s2c_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [17:0] ang_i,
  output cw_t                cos_o,
  output cw_t                sin_o
);

  cw_t  x_q [NStages+1];
  cw_t  y_q [NStages+1];
  zw_t  z_q [NStages+1];
  logic f_q [NStages+1];
  red_t red;

  assign red = reduce(ang_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= GainQ24;
      y_q[0] <= '0;
      z_q[0] <= ZW'(red.ang) <<< 12;
      f_q[0] <= red.flip;
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_deg(SIdxW'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_deg(SIdxW'(i));
        end
      end
    end
  end

  assign cos_o = f_q[NStages] ? -x_q[NStages] : x_q[NStages];
  assign sin_o = f_q[NStages] ? -y_q[NStages] : y_q[NStages];

endmodule

@@ hdl/spherical_to_cartesian.sv @@
// spherical_to_cartesian: top level, two cordic pipelines and product stages
// depends on s2c_pkg and s2c_cordic
//
//   channel  handshake        payload
//   input    start_i / busy_o radius_i, polar_deg_i, azimuth_deg_i
//   output   done_o strobe    pos_x_o, pos_y_o, pos_z_o
//
// one word per cycle; the path is the cordic pipeline plus two product stages
// and one output register. busy_o is held low, the pipeline always advances.
// reset clears the valid bits only.
module spherical_to_cartesian import s2c_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [15:0]        radius_i,
  input  logic [15:0]        polar_deg_i,
  input  logic signed [16:0] azimuth_deg_i,
  output logic               done_o,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o
);

  localparam int Lat = NStages + 1;
  localparam int PW  = 2 * CW;

  logic [Lat+2:0] vld_q;
  logic [15:0]    r_q [Lat];
  cw_t ct, st, cp, sp;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat+1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= radius_i;
    for (int i = 1; i < Lat; i++) r_q[i] <= r_q[i-1];
  end

  s2c_cordic u_polar (
    .clk_i(clk_i), .en_i(1'b1),
    .ang_i(18'($signed({1'b0, polar_deg_i}))), .cos_o(ct), .sin_o(st)
  );
  s2c_cordic u_azim (
    .clk_i(clk_i), .en_i(1'b1),
    .ang_i(18'(azimuth_deg_i)), .cos_o(cp), .sin_o(sp)
  );

  // stage a: sin(polar) times cos and sin(azimuth), rounded to q24; cos(polar) passed on
  logic signed [PW-1:0] pxa, pya;
  cw_t                  fx_q, fy_q, fz_q;
  logic [15:0]          ra_q;
  assign pxa = PW'(st) * PW'(cp) + PW'(64'sd8388608);
  assign pya = PW'(st) * PW'(sp) + PW'(64'sd8388608);

  always_ff @(posedge clk_i) begin
    fx_q <= CW'(pxa >>> 24);
    fy_q <= CW'(pya >>> 24);
    fz_q <= ct;
    ra_q <= r_q[Lat-1];
  end

  // stage b: radius times factor, rounded to integer
  localparam int RW = CW + 17;
  logic signed [RW-1:0] mx, my, mz;
  logic signed [RW-1:0] mx_q, my_q, mz_q;
  assign mx = RW'($signed({1'b0, ra_q})) * RW'(fx_q) + RW'(46'sd8388608);
  assign my = RW'($signed({1'b0, ra_q})) * RW'(fy_q) + RW'(46'sd8388608);
  assign mz = RW'($signed({1'b0, ra_q})) * RW'(fz_q) + RW'(46'sd8388608);

  always_ff @(posedge clk_i) begin
    mx_q <= mx >>> 24;
    my_q <= my >>> 24;
    mz_q <= mz >>> 24;
  end

  function automatic logic signed [16:0] sat(input logic signed [RW-1:0] v);
    logic signed [16:0] o;
    if (v > RW'(OutMax))       o = OutMax;
    else if (v < -RW'(OutMax)) o = -OutMax;
    else                       o = v[16:0];
    return o;
  endfunction

  always_ff @(posedge clk_i) begin
    pos_x_o <= sat(mx_q);
    pos_y_o <= sat(my_q);
    pos_z_o <= sat(mz_q);
  end

  assign done_o = vld_q[Lat+2];

endmodule

@@ bench/tb_spherical_to_cartesian.sv @@
// tb_spherical_to_cartesian: self-checking bench for spherical_to_cartesian
// predicts x, y, z with a local degree cordic model; depends on s2c_pkg and the rtl

module tb_spherical_to_cartesian;
  import s2c_pkg::*;

  localparam int NStg = (CordicStages < TableLen) ? CordicStages : TableLen;

  typedef struct {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } pos_t;

  int err_cnt = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  class pos_scoreboard;
    pos_t pending[$];
    longint atan_q20[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7};

    function longint round_q24(input longint v);
      return (v + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function longint clamp_out(input longint v);
      if (v > 65535) return 65535;
      if (v < -65535) return -65535;
      return v;
    endfunction

    function void rotate(input longint ang, output longint cs, output longint sn);
      longint cx, sy, za, nx;
      bit flip;
      cx = 10188014;
      sy = 0;
      flip = 0;
      if (ang >= 46080) ang -= 92160;
      if (ang < -46080) ang += 92160;
      if (ang > 23040) begin
        ang -= 46080;
        flip = 1;
      end else if (ang < -23040) begin
        ang += 46080;
        flip = 1;
      end
      za = ang * 4096;
      for (int i = 0; i < NStg; i++) begin
        if (za >= 0) begin
          nx = cx - (sy >>> i);
          sy = sy + (cx >>> i);
          za -= atan_q20[i];
        end else begin
          nx = cx + (sy >>> i);
          sy = sy - (cx >>> i);
          za += atan_q20[i];
        end
        cx = nx;
      end
      cs = flip ? -cx : cx;
      sn = flip ? -sy : sy;
    endfunction

    function void note_input(input logic [15:0] r, input logic [15:0] th,
                             input logic signed [16:0] ph);
      longint ct, st, cp, sp, rr;
      pos_t p;
      rr = r;
      rotate(longint'(th), ct, st);
      rotate(longint'(ph), cp, sp);
      p.x = 17'(clamp_out(round_q24(rr * round_q24(st * cp))));
      p.y = 17'(clamp_out(round_q24(rr * round_q24(st * sp))));
      p.z = 17'(clamp_out(round_q24(rr * ct)));
      pending.push_back(p);
    endfunction

    task check_result(input logic signed [16:0] x, input logic signed [16:0] y,
                      input logic signed [16:0] z);
      pos_t p;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
        return;
      end
      p = pending.pop_front();
      if (x !== p.x) report_mismatch("pos_x", x, p.x);
      if (y !== p.y) report_mismatch("pos_y", y, p.y);
      if (z !== p.z) report_mismatch("pos_z", z, p.z);
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic busy_o;
  logic [15:0] radius_i = '0;
  logic [15:0] polar_deg_i = '0;
  logic signed [16:0] azimuth_deg_i = '0;
  logic done_o;
  logic signed [16:0] pos_x_o, pos_y_o, pos_z_o;

  pos_scoreboard sb = new();
  int idle_pct = 0;

  always #5 clk_i = ~clk_i;

  spherical_to_cartesian uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .radius_i, .polar_deg_i, .azimuth_deg_i,
    .done_o, .pos_x_o, .pos_y_o, .pos_z_o
  );

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(pos_x_o, pos_y_o, pos_z_o);
  end

  // keeps start high across back-to-back words, one assignment per edge, unless idle_pct inserts gaps
  task automatic send_word(input logic [15:0] r, input logic [15:0] th,
                           input logic signed [16:0] ph);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    radius_i <= r;
    polar_deg_i <= th;
    azimuth_deg_i <= ph;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_input(r, th, ph);
  endtask

  task automatic send_random();
    logic [15:0] r, th;
    logic signed [16:0] ph;
    int k;
    k = $urandom_range(9);
    r = (k == 0) ? 16'($urandom_range(15)) : 16'($urandom);
    if (k == 1) th = 16'($urandom);
    else if (k == 2) th = 16'(23040 + $urandom_range(4) - 2);
    else th = 16'($urandom_range(46080));
    if (k == 3) ph = 17'($urandom);
    else if (k == 4) ph = 17'(-46080 + 17'($urandom_range(4)));
    else ph = 17'(int'($urandom_range(92160)) - 46080);
    send_word(r, th, ph);
  endtask

  initial begin
    int pcts[4];
    pcts = '{0, 78, 0, 36};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_word(16'd0, 16'd0, 17'sd0);
    send_word(16'hffff, 16'd0, 17'sd0);
    send_word(16'hffff, 16'd46080, 17'sd0);
    send_word(16'hffff, 16'd23040, 17'sd0);
    send_word(16'hffff, 16'd23040, 17'sd23040);
    send_word(16'hffff, 16'd23040, -17'sd23040);
    send_word(16'hffff, 16'd23040, 17'sd46080);
    send_word(16'hffff, 16'd23040, -17'sd46080);
    send_word(16'hffff, 16'd23041, 17'sd23041);
    send_word(16'hffff, 16'd23039, -17'sd23041);
    send_word(16'hffff, 16'hffff, 17'sd65535);
    send_word(16'hffff, 16'd46081, -17'sd65536);
    send_word(16'd1, 16'd11520, 17'sd11520);
    send_word(16'h8000, 16'd15360, -17'sd34560);
    send_word(16'd12345, 16'd30000, 17'sd1);
    send_word(16'hffff, 16'd11520, 17'sd11520);
    foreach (pcts[p]) begin
      idle_pct = pcts[p];
      repeat (350) send_random();
    end
    start_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (CordicStages + 10) @(posedge clk_i);
    if (err_cnt == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hdl/s2c_pkg.sv
hdl/s2c_cordic.sv
hdl/spherical_to_cartesian.sv
bench/tb_spherical_to_cartesian.sv
